// ===== rtl/owrs_pkg.sv =====
// ----------------------------------------------------------------------------
// owrs_pkg
// Types, codes and the CRC8 helper shared by the ROM search block.
// ----------------------------------------------------------------------------
`default_nettype none

package owrs_pkg;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_NEXT  = 2'd1,
        OP_PAIR  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CMD = 2'd0,
        KIND_DIR = 2'd1,
        KIND_END = 2'd2,
        KIND_RSV = 2'd3
    } kind_t;

    localparam logic [6:0] ROM_BITS     = 7'd64;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    typedef struct packed {
        logic [1:0] operation;
        logic       presence;
        logic       true_bit;
        logic       complement_bit;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic        found;
        logic [63:0] rom_value;
        logic        last_device;
        logic [3:0]  family_branch;
        logic [6:0]  bit_position;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        logic       mix;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++)
        begin
            mix  = crc[0] ^ data[0];
            crc  = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/owrs_fifo.sv =====
// ----------------------------------------------------------------------------
// owrs_fifo
// Result queue: takes up to two words per cycle, gives one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module owrs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push0,
    input  wire                        push1,
    input  owrs_pkg::result_t          din0,
    input  owrs_pkg::result_t          din1,
    input  wire                        pop,
    output owrs_pkg::result_t          dout,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import owrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, wr_plus1, wr_plus2;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        wr_plus1   = ptr_inc(wr_reg);
        wr_plus2   = ptr_inc(wr_plus1);
        wr_next    = wr_reg;
        if (push0)
        begin
            wr_next = push1 ? wr_plus2 : wr_plus1;
        end
        rd_next    = pop ? ptr_inc(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push0) + CW'(push0 & push1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_reg] <= din0;
        end
        if (push0 && push1)
        begin
            mem_reg[wr_plus1] <= din1;
        end
    end

    assign dout  = mem_reg[rd_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/owrs_core.sv =====
// ----------------------------------------------------------------------------
// owrs_core
// Search state and one tree-walk step per item; emits up to two result words.
// ----------------------------------------------------------------------------
`default_nettype none

module owrs_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                step,
    input  owrs_pkg::item_t    item,
    output owrs_pkg::result_t  res0,
    output owrs_pkg::result_t  res1,
    output logic [1:0]         res_count
);
    import owrs_pkg::*;

    logic [63:0] rom_reg, rom_next;
    logic [6:0]  ld_reg, ld_next;
    logic [6:0]  lzp_reg, lzp_next;
    logic [3:0]  fam_reg, fam_next;
    logic        flag_reg, flag_next;
    logic [6:0]  bc_reg, bc_next;
    logic [7:0]  crc_reg, crc_next;
    logic        active_reg, active_next;

    function automatic result_t end_word(input logic f, input logic [63:0] rom,
                                         input logic last, input logic [3:0] fam);
        result_t r;
        r               = '0;
        r.kind          = KIND_END;
        r.found         = f;
        r.rom_value     = rom;
        r.last_device   = last;
        r.family_branch = fam;
        return r;
    endfunction

    always_comb
    begin
        logic [6:0] pos;
        logic [5:0] idx;
        logic       dir;
        logic       found;
        pos         = bc_reg;
        idx         = pos[5:0] - 6'd1;
        dir         = 1'b0;
        found       = 1'b0;
        rom_next    = rom_reg;
        ld_next     = ld_reg;
        lzp_next    = lzp_reg;
        fam_next    = fam_reg;
        flag_next   = flag_reg;
        bc_next     = bc_reg;
        crc_next    = crc_reg;
        active_next = active_reg;
        res0        = '0;
        res1        = '0;
        res_count   = 2'd0;
        unique case (op_t'(item.operation))
            OP_FIRST, OP_NEXT:
            begin
                active_next = 1'b0;
                crc_next    = '0;
                if (op_t'(item.operation) == OP_FIRST)
                begin
                    ld_next   = '0;
                    fam_next  = '0;
                    flag_next = 1'b0;
                end
                res_count = 2'd1;
                if (flag_next)
                begin
                    res0 = end_word(1'b0, rom_reg, flag_next, fam_next);
                end
                else if (!item.presence)
                begin
                    ld_next   = '0;
                    fam_next  = '0;
                    flag_next = 1'b0;
                    res0      = end_word(1'b0, rom_reg, 1'b0, 4'd0);
                end
                else
                begin
                    bc_next     = 7'd1;
                    lzp_next    = '0;
                    active_next = 1'b1;
                    res0.kind   = KIND_CMD;
                end
            end
            OP_PAIR:
            begin
                if (active_reg && item.true_bit && item.complement_bit)
                begin
                    active_next = 1'b0;
                    ld_next     = '0;
                    fam_next    = '0;
                    flag_next   = 1'b0;
                    res0        = end_word(1'b0, rom_reg, 1'b0, 4'd0);
                    res_count   = 2'd1;
                end
                else if (active_reg)
                begin
                    if (item.true_bit != item.complement_bit)
                    begin
                        dir = item.true_bit;
                    end
                    else
                    begin
                        if (pos < ld_reg)
                        begin
                            dir = rom_reg[idx];
                        end
                        else
                        begin
                            dir = (pos == ld_reg);
                        end
                        if (!dir)
                        begin
                            lzp_next = pos;
                            if (pos < FAMILY_LIMIT)
                            begin
                                fam_next = pos[3:0];
                            end
                        end
                    end
                    rom_next[idx] = dir;
                    if (idx[2:0] == 3'b111)
                    begin
                        crc_next = crc8_byte(crc_reg, rom_next[{idx[5:3], 3'b000} +: 8]);
                    end
                    res0.kind         = KIND_DIR;
                    res0.direction    = dir;
                    res0.bit_position = pos;
                    res_count         = 2'd1;
                    bc_next           = pos + 7'd1;
                    if (pos >= ROM_BITS)
                    begin
                        active_next = 1'b0;
                        if (crc_next == 8'd0)
                        begin
                            ld_next = lzp_next;
                            if (lzp_next == 7'd0)
                            begin
                                flag_next = 1'b1;
                            end
                            found = 1'b1;
                        end
                        if (!found || rom_next[7:0] == 8'd0)
                        begin
                            ld_next   = '0;
                            fam_next  = '0;
                            flag_next = 1'b0;
                            found     = 1'b0;
                        end
                        res1      = end_word(found, rom_next, flag_next, fam_next);
                        res_count = 2'd2;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg    <= '0;
            ld_reg     <= '0;
            lzp_reg    <= '0;
            fam_reg    <= '0;
            flag_reg   <= 1'b0;
            bc_reg     <= 7'd1;
            crc_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            rom_reg    <= rom_next;
            ld_reg     <= ld_next;
            lzp_reg    <= lzp_next;
            fam_reg    <= fam_next;
            flag_reg   <= flag_next;
            bc_reg     <= bc_next;
            crc_reg    <= crc_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/onewire_rom_search.sv =====
// ----------------------------------------------------------------------------
// onewire_rom_search
// Master side of the 1-Wire search ROM tree walk, bus timing excluded.
// ----------------------------------------------------------------------------
// Slave channel s_*: one word per start (first or next search, with the
// presence bit) or per answered bit pair. Master channel m_*: one result
// word per accepted word, two after the 64th bit pair (direction, then
// the end-of-search report). Bit pairs while idle and unused codes give
// nothing.
// A word accepted into the input register is stepped from there into the
// result queue once the queue has room, and then shows on m_tvalid.
// Throughput: one word per cycle while the queue has room; the search
// state steps per word; the four-entry queue absorbs the extra end word.
// s_tready drops only while the queue holds more than two words, so a
// stalled receiver backs up through the queue into the input register.
// Reset clears the search state (bit counter at 1, idle) and empties the
// queue and input register.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // presence, true_bit, complement_bit, pad
    input  wire  [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // direction, found, rom_value[63:0],
                                   // last_device, family_branch[3:0],
                                   // bit_position[6:0], pad
    output logic [1:0]  m_tuser    // kind
);
    import owrs_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);

    logic              in_v_reg, in_v_next;
    item_t             item_reg;
    logic              room;
    logic              step;
    result_t           res0, res1, dout;
    logic [1:0]        res_count;
    logic [QCW-1:0]    q_count;
    logic              pop;

    assign room      = (q_count <= QCW'(QDEPTH - 2));
    assign step      = in_v_reg && room;
    assign s_tready  = !in_v_reg || room;
    assign in_v_next = (s_tvalid && s_tready) || (in_v_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.operation      <= s_tuser;
            item_reg.presence       <= s_tdata[0];
            item_reg.true_bit       <= s_tdata[1];
            item_reg.complement_bit <= s_tdata[2];
        end
    end

    owrs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    owrs_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push0 (step && res_count != 2'd0),
        .push1 (step && res_count == 2'd2),
        .din0  (res0),
        .din1  (res1),
        .pop   (pop),
        .dout  (dout),
        .count (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tuser  = dout.kind;
    assign m_tdata  = {2'b00, dout.bit_position, dout.family_branch, dout.last_device,
                       dout.rom_value, dout.found, dout.direction};

endmodule

`default_nettype wire

// ===== rtl/owrs_checker.sv =====
// ----------------------------------------------------------------------------
// owrs_checker
// Port-level checks on the ROM search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owrs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [79:0] m_tdata,
    input wire [1:0]  m_tuser
);
    import owrs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result queue");

    a_dir_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_DIR |->
            m_tdata[77:71] != 7'd0 && m_tdata[77:71] <= ROM_BITS && m_tdata[1] == 1'b0)
        else $error("direction word with bad bit position or found set");

    a_found_family: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_END && m_tdata[1] |-> m_tdata[9:2] != 8'd0)
        else $error("found reported with zero family byte");

    a_cmd_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CMD |-> m_tdata == 80'd0)
        else $error("search command word carries data");

endmodule

bind onewire_rom_search owrs_checker u_owrs_checker (.*);

`default_nettype wire
